// ===== src/quintic_spline_kernel_eval_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quintic spline kernel block
// Property wrappers with a clock, a reset that disables the check and an error report.
// ----------------------------------------------------------------------------
`ifndef QUINTIC_SPLINE_KERNEL_EVAL_ASSERT_SVH
`define QUINTIC_SPLINE_KERNEL_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSKE_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QSKE_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qske_pkg.sv =====
// ----------------------------------------------------------------------------
// Quintic spline kernel package
// Widths, fixed-point constants, register codes and lane control types.
// ----------------------------------------------------------------------------
package qske_pkg;

  // Port widths.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W    = 32;
  localparam int SEP_W     = 32;
  localparam int WEIGHT_W  = 47;
  localparam int GRAD_W    = 48;

  // Internal fixed-point widths. All kernel terms are Q.24.
  localparam int FRAC       = 24;
  localparam int Q_SHIFT    = 8;
  localparam int T_W        = 26;
  localparam int P2_W       = 28;
  localparam int P4_W       = 32;
  localparam int P5_W       = 32;
  localparam int BR_W       = 38;
  localparam int B_W        = 33;
  localparam int DR_W       = 40;
  localparam int DMAG_W     = 34;
  localparam int WSUM_W     = 42;
  localparam int SMAG_W     = 43;
  localparam int SMAG_SPLIT = 16;
  localparam int M_W        = 60;

  localparam int NUM_LANES  = 3;
  localparam int NUM_STAGES = 12;

  // Segment knots 3, 2 and 1 in Q.24.
  localparam logic [T_W-1:0] T_K3 = 26'd50331648;
  localparam logic [T_W-1:0] T_K2 = 26'd33554432;
  localparam logic [T_W-1:0] T_K1 = 26'd16777216;

  // Bracket coefficients.
  localparam logic [BR_W-1:0] W_K2 = 38'd6;
  localparam logic [BR_W-1:0] W_K1 = 38'd15;
  localparam logic [DR_W-1:0] G_K3 = 40'd5;
  localparam logic [DR_W-1:0] G_K2 = 40'd30;
  localparam logic [DR_W-1:0] G_K1 = 40'd75;

  // Register reset values.
  localparam logic [CFG_W-1:0] INV_H_RESET    = 32'd65536;
  localparam logic [CFG_W-1:0] WEIGHT_F_RESET = 32'd44494;
  localparam logic [CFG_W-1:0] GRAD_F_RESET   = 32'd44494;

  // Gradient clip limits, two's complement Q24.24.
  localparam logic [GRAD_W-1:0] GRAD_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [GRAD_W-1:0] GRAD_NEG_MAX = 48'h8000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_H    = 2'd0,
    REG_WEIGHT_F = 2'd1,
    REG_GRAD_F   = 2'd2
  } cfg_reg_t;

  // Stage advance strobes for a power lane.
  typedef struct packed {
    logic sq;
    logic quad;
    logic quint;
  } pow_adv_t;

  // Stage advance strobes for a gradient lane.
  typedef struct packed {
    logic prod;
    logic sum;
    logic clip;
  } grad_adv_t;

endpackage

// ===== src/qske_if.sv =====
// ----------------------------------------------------------------------------
// Quintic spline kernel channels
// Valid/ready channels for neighbor-pair items and kernel result items.
// ----------------------------------------------------------------------------
interface qske_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic        [qske_pkg::DIST_W-1:0]  distance;
  logic signed [qske_pkg::SEP_W-1:0]   sep_x;
  logic signed [qske_pkg::SEP_W-1:0]   sep_y;
  logic signed [qske_pkg::SEP_W-1:0]   sep_z;

  modport source (output valid, func, distance, sep_x, sep_y, sep_z, input ready);
  modport sink (input valid, func, distance, sep_x, sep_y, sep_z, output ready);
endinterface

interface qske_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [qske_pkg::WEIGHT_W-1:0] weight;
  logic signed [qske_pkg::GRAD_W-1:0]   grad_x;
  logic signed [qske_pkg::GRAD_W-1:0]   grad_y;
  logic signed [qske_pkg::GRAD_W-1:0]   grad_z;
  logic                                 saturated;

  modport source (output valid, weight, grad_x, grad_y, grad_z, saturated, input ready);
  modport sink (input valid, weight, grad_x, grad_y, grad_z, saturated, output ready);
endinterface

// ===== src/qske_pow_lane.sv =====
// ----------------------------------------------------------------------------
// Quintic spline kernel power lane
// Three-stage pipeline forming t^4 and t^5 of one Q.24 segment term.
// ----------------------------------------------------------------------------
module qske_pow_lane (
  input  logic                        clk,
  input  qske_pkg::pow_adv_t          adv,
  input  logic [qske_pkg::T_W-1:0]    t,
  output logic [qske_pkg::P4_W-1:0]   p4,
  output logic [qske_pkg::P5_W-1:0]   p5
);

  logic [qske_pkg::T_W-1:0]      t_a;
  logic [qske_pkg::T_W-1:0]      t_b;
  logic [qske_pkg::P2_W-1:0]     p2;
  logic [qske_pkg::P4_W-1:0]     p4_b;
  logic [2*qske_pkg::T_W-1:0]    sq_full;
  logic [2*qske_pkg::P2_W-1:0]   quad_full;
  logic [qske_pkg::P4_W+qske_pkg::T_W-1:0] quint_full;

  // Each product is truncated back to Q.24.
  assign sq_full    = t * t;
  assign quad_full  = p2 * p2;
  assign quint_full = p4_b * t_b;

  // Square stage.
  always_ff @(posedge clk) begin
    if (adv.sq) begin
      p2  <= sq_full[qske_pkg::FRAC+qske_pkg::P2_W-1:qske_pkg::FRAC];
      t_a <= t;
    end
  end

  // Fourth-power stage.
  always_ff @(posedge clk) begin
    if (adv.quad) begin
      p4_b <= quad_full[qske_pkg::FRAC+qske_pkg::P4_W-1:qske_pkg::FRAC];
      t_b  <= t_a;
    end
  end

  // Fifth-power stage; the fourth power travels alongside.
  always_ff @(posedge clk) begin
    if (adv.quint) begin
      p5 <= quint_full[qske_pkg::FRAC+qske_pkg::P5_W-1:qske_pkg::FRAC];
      p4 <= p4_b;
    end
  end

endmodule

// ===== src/qske_grad_lane.sv =====
// ----------------------------------------------------------------------------
// Quintic spline kernel gradient lane
// Scales one separation component by the gradient scalar, then clips.
// ----------------------------------------------------------------------------
module qske_grad_lane (
  input  logic                               clk,
  input  qske_pkg::grad_adv_t                adv,
  input  logic [qske_pkg::SEP_W-1:0]         sep,
  input  logic [qske_pkg::SMAG_W-1:0]        smag,
  input  logic                               sneg,
  output logic signed [qske_pkg::GRAD_W-1:0] comp,
  output logic                               sat
);

  localparam int HI_W = qske_pkg::SMAG_W - qske_pkg::SMAG_SPLIT;

  logic [qske_pkg::SEP_W-1:0]                       vmag;
  logic [qske_pkg::SEP_W+HI_W-1:0]                  prod_hi;
  logic [qske_pkg::SEP_W+qske_pkg::SMAG_SPLIT-1:0]  prod_lo;
  logic                                             neg_a;
  logic [qske_pkg::M_W-1:0]                         m;
  logic                                             neg_b;
  logic                                             neg;
  logic                                             over_neg;
  logic                                             over_pos;

  // Magnitude of the component; the most negative value maps to 2^31.
  assign vmag = sep[qske_pkg::SEP_W-1] ? -sep : sep;

  // Split product: the scalar is cut at bit 16 so each multiplier stays narrow.
  always_ff @(posedge clk) begin
    if (adv.prod) begin
      prod_hi <= vmag * smag[qske_pkg::SMAG_W-1:qske_pkg::SMAG_SPLIT];
      prod_lo <= vmag * smag[qske_pkg::SMAG_SPLIT-1:0];
      neg_a   <= sneg ^ sep[qske_pkg::SEP_W-1];
    end
  end

  // Recombine into the Q24.24 magnitude, truncated toward zero.
  always_ff @(posedge clk) begin
    if (adv.sum) begin
      m     <= qske_pkg::M_W'(prod_hi)
             + qske_pkg::M_W'(prod_lo[qske_pkg::SEP_W+qske_pkg::SMAG_SPLIT-1:
                                      qske_pkg::SMAG_SPLIT]);
      neg_b <= neg_a;
    end
  end

  // A zero magnitude is never negative. Clip to the field range.
  assign neg      = neg_b && (m != '0);
  assign over_neg = (|m[qske_pkg::M_W-1:qske_pkg::GRAD_W])
                  || (m[qske_pkg::GRAD_W-1] && (|m[qske_pkg::GRAD_W-2:0]));
  assign over_pos = |m[qske_pkg::M_W-1:qske_pkg::GRAD_W-1];

  always_ff @(posedge clk) begin
    if (adv.clip) begin
      if (neg) begin
        comp <= over_neg ? qske_pkg::GRAD_NEG_MAX : -m[qske_pkg::GRAD_W-1:0];
        sat  <= over_neg;
      end else begin
        comp <= over_pos ? qske_pkg::GRAD_POS_MAX : m[qske_pkg::GRAD_W-1:0];
        sat  <= over_pos;
      end
    end
  end

endmodule

// ===== src/quintic_spline_kernel_eval.sv =====
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator
// Fully pipelined SPH quintic kernel weight and gradient for neighbor pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the items channel (valid/ready) with func, distance and
//   the separation vector; func low asks for the weight, high for the
//   gradient. Each item gives one item on the results channel, in order.
//   Configuration registers are written through cfg_wr_en, cfg_index and
//   cfg_data while the block is idle; indexes beyond the list are ignored.
//   From acceptance to results.valid an item passes through the 12
//   register stages: input, q product, segment terms, three stages of
//   power lanes, bracket merge, factor products, factor sums and three
//   stages of gradient lanes. Throughput is one item per cycle while results.ready is high.
//   When results.ready is low the final stage holds its item, and earlier
//   stages keep moving into any empty stage, so items.ready only drops once
//   every stage is full. Synchronous reset empties the pipeline and loads
//   the register reset values; items.ready is low during reset.
// ----------------------------------------------------------------------------
`include "quintic_spline_kernel_eval_assert.svh"

module quintic_spline_kernel_eval (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [qske_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qske_pkg::CFG_W-1:0]         cfg_data,
  qske_in_if.sink                            items,
  qske_out_if.source                         results
);

  localparam int NS       = qske_pkg::NUM_STAGES;
  localparam int NL       = qske_pkg::NUM_LANES;
  localparam int SEP_LAST = 9;
  localparam int WH_W     = qske_pkg::CFG_W + qske_pkg::B_W - qske_pkg::FRAC;
  localparam int WL_W     = qske_pkg::CFG_W + qske_pkg::FRAC;
  localparam int GH_W     = qske_pkg::CFG_W + qske_pkg::DMAG_W - qske_pkg::FRAC;

  typedef struct packed {
    logic use2;
    logic use1;
    logic w_act;
    logic g_act;
  } seg_flags_t;

  // Configuration registers.
  logic [qske_pkg::CFG_W-1:0] inv_h;
  logic [qske_pkg::CFG_W-1:0] weight_f;
  logic [qske_pkg::CFG_W-1:0] grad_f;

  // Pipeline control.
  logic [NS:1]   v;
  logic [NS:1]   v_prev;
  logic [NS+1:1] en;

  // Payload stages.
  logic [2:0][qske_pkg::SEP_W-1:0] sep_pipe [1:SEP_LAST];
  logic                            s1_func;
  logic [qske_pkg::DIST_W-1:0]     s1_dist;
  logic                            s2_func;
  logic [2*qske_pkg::CFG_W-1:0]    s2_q32;
  logic [qske_pkg::T_W-1:0]        q24;
  logic [qske_pkg::T_W-1:0]        s3_t [NL];
  seg_flags_t                      flags_pipe [3:6];
  logic [qske_pkg::P4_W-1:0]       p4 [NL];
  logic [qske_pkg::P5_W-1:0]       p5 [NL];
  logic [qske_pkg::BR_W-1:0]       b_u;
  logic [qske_pkg::DR_W-1:0]       d_u;
  logic [qske_pkg::DR_W-1:0]       d_abs;
  logic [qske_pkg::B_W-1:0]        s7_b;
  logic [qske_pkg::DMAG_W-1:0]     s7_dmag;
  logic                            s7_dneg;
  logic [WH_W-1:0]                 s8_wh;
  logic [WL_W-1:0]                 s8_wl;
  logic [GH_W-1:0]                 s8_gh;
  logic [WL_W-1:0]                 s8_gl;
  logic                            s8_dneg;
  logic [qske_pkg::WSUM_W-1:0]     w_pipe [9:NS];
  logic [qske_pkg::SMAG_W-1:0]     s9_smag;
  logic                            s9_dneg;
  qske_pkg::pow_adv_t              pow_adv;
  qske_pkg::grad_adv_t             grad_adv;
  logic [qske_pkg::GRAD_W-1:0]     grad_c [NL];
  logic [NL-1:0]                   sat_c;

  // Register writes; unknown indexes fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_h    <= qske_pkg::INV_H_RESET;
      weight_f <= qske_pkg::WEIGHT_F_RESET;
      grad_f   <= qske_pkg::GRAD_F_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        qske_pkg::REG_INV_H:    inv_h    <= cfg_data;
        qske_pkg::REG_WEIGHT_F: weight_f <= cfg_data;
        qske_pkg::REG_GRAD_F:   grad_f   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[NS+1] = results.ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign v_prev      = {v[NS-1:1], items.valid};
  assign items.ready = en[1] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v[k] <= v_prev[k];
        end
      end
    end
  end

  // Separation vector rides along until the gradient lanes take it.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sep_pipe[1] <= {items.sep_z, items.sep_y, items.sep_x};
    end
    for (int k = 2; k <= SEP_LAST; k++) begin
      if (en[k]) begin
        sep_pipe[k] <= sep_pipe[k-1];
      end
    end
  end

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_func <= items.func;
      s1_dist <= items.distance;
    end
  end

  // Stage 2: exact Q32.32 scaled distance.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_func <= s1_func;
      s2_q32  <= s1_dist * inv_h;
    end
  end

  // Stage 3: segment choice on the exact product and the three Q.24 terms.
  // The segment flags then ride along to the merge stage.
  assign q24 = s2_q32[qske_pkg::Q_SHIFT+qske_pkg::T_W-1:qske_pkg::Q_SHIFT];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_t[0]             <= qske_pkg::T_K3 - q24;
      s3_t[1]             <= qske_pkg::T_K2 - q24;
      s3_t[2]             <= qske_pkg::T_K1 - q24;
      flags_pipe[3].use2  <= s2_q32[2*qske_pkg::CFG_W-1:qske_pkg::CFG_W] < 32'd2;
      flags_pipe[3].use1  <= s2_q32[2*qske_pkg::CFG_W-1:qske_pkg::CFG_W] == '0;
      flags_pipe[3].w_act <= !s2_func
                           && (s2_q32[2*qske_pkg::CFG_W-1:qske_pkg::CFG_W] < 32'd3);
      flags_pipe[3].g_act <= s2_func && (s2_q32 != '0)
                           && (s2_q32[2*qske_pkg::CFG_W-1:qske_pkg::CFG_W] < 32'd3);
    end
    for (int k = 4; k <= 6; k++) begin
      if (en[k]) begin
        flags_pipe[k] <= flags_pipe[k-1];
      end
    end
  end

  // Stages 4 to 6: one power lane per segment term.
  assign pow_adv.sq    = en[4];
  assign pow_adv.quad  = en[5];
  assign pow_adv.quint = en[6];

  for (genvar i = 0; i < NL; i++) begin : g_pow
    qske_pow_lane u_pow_lane (
      .clk (clk),
      .adv (pow_adv),
      .t   (s3_t[i]),
      .p4  (p4[i]),
      .p5  (p5[i])
    );
  end

  // Stage 7: merge the lanes into the weight and derivative brackets.
  always_comb begin
    b_u = qske_pkg::BR_W'(p5[0])
        - (flags_pipe[6].use2 ? qske_pkg::BR_W'(p5[1]) * qske_pkg::W_K2 : '0)
        + (flags_pipe[6].use1 ? qske_pkg::BR_W'(p5[2]) * qske_pkg::W_K1 : '0);
    d_u = (flags_pipe[6].use2 ? qske_pkg::DR_W'(p4[1]) * qske_pkg::G_K2 : '0)
        - qske_pkg::DR_W'(p4[0]) * qske_pkg::G_K3
        - (flags_pipe[6].use1 ? qske_pkg::DR_W'(p4[2]) * qske_pkg::G_K1 : '0);
    d_abs = d_u[qske_pkg::DR_W-1] ? -d_u : d_u;
  end

  // A negative weight bracket from truncation clamps to zero; inactive
  // items carry zero so every later product is zero.
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_b    <= (flags_pipe[6].w_act && !b_u[qske_pkg::BR_W-1])
               ? b_u[qske_pkg::B_W-1:0] : '0;
      s7_dmag <= flags_pipe[6].g_act ? d_abs[qske_pkg::DMAG_W-1:0] : '0;
      s7_dneg <= d_u[qske_pkg::DR_W-1];
    end
  end

  // Stage 8: factor products, split at the Q.24 point.
  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_wh   <= weight_f * s7_b[qske_pkg::B_W-1:qske_pkg::FRAC];
      s8_wl   <= weight_f * s7_b[qske_pkg::FRAC-1:0];
      s8_gh   <= grad_f * s7_dmag[qske_pkg::DMAG_W-1:qske_pkg::FRAC];
      s8_gl   <= grad_f * s7_dmag[qske_pkg::FRAC-1:0];
      s8_dneg <= s7_dneg;
    end
  end

  // Stage 9: recombine. The clamped weight bracket stays below 2^33, so the
  // weight never reaches the top of its output range. The weight then rides
  // along beside the gradient lanes.
  always_ff @(posedge clk) begin
    if (en[9]) begin
      w_pipe[9] <= qske_pkg::WSUM_W'(s8_wh)
                 + qske_pkg::WSUM_W'(s8_wl[WL_W-1:qske_pkg::FRAC]);
      s9_smag   <= qske_pkg::SMAG_W'(s8_gh)
                 + qske_pkg::SMAG_W'(s8_gl[WL_W-1:qske_pkg::FRAC]);
      s9_dneg   <= s8_dneg;
    end
    for (int k = 10; k <= NS; k++) begin
      if (en[k]) begin
        w_pipe[k] <= w_pipe[k-1];
      end
    end
  end

  // Stages 10 to 12: one gradient lane per vector component.
  assign grad_adv.prod = en[10];
  assign grad_adv.sum  = en[11];
  assign grad_adv.clip = en[12];

  for (genvar i = 0; i < NL; i++) begin : g_grad
    qske_grad_lane u_grad_lane (
      .clk  (clk),
      .adv  (grad_adv),
      .sep  (sep_pipe[SEP_LAST][i]),
      .smag (s9_smag),
      .sneg (s9_dneg),
      .comp (grad_c[i]),
      .sat  (sat_c[i])
    );
  end

  // Result channel.
  assign results.valid     = v[NS];
  assign results.weight    = qske_pkg::WEIGHT_W'(w_pipe[NS]);
  assign results.grad_x    = grad_c[0];
  assign results.grad_y    = grad_c[1];
  assign results.grad_z    = grad_c[2];
  assign results.saturated = |sat_c;

  // Checks.
  `QSKE_ASSERT_NEXT(a_accept_enters, clk, rst, items.valid && items.ready, v[1],
    "accepted item did not enter the first stage")
  `QSKE_ASSERT_SAME(a_full_stall_blocks, clk, rst, (&v) && !results.ready, !items.ready,
    "item accepted while every stage is full and the output is stalled")
  `QSKE_ASSERT_SAME(a_one_kind, clk, rst, results.valid && (results.weight != '0),
    (results.grad_x == '0) && (results.grad_y == '0) && (results.grad_z == '0),
    "weight and gradient both nonzero in one result")
  `QSKE_ASSERT_SAME(a_sat_at_limit, clk, rst, results.valid && results.saturated,
    (results.grad_x == qske_pkg::GRAD_POS_MAX) || (results.grad_x == qske_pkg::GRAD_NEG_MAX) ||
    (results.grad_y == qske_pkg::GRAD_POS_MAX) || (results.grad_y == qske_pkg::GRAD_NEG_MAX) ||
    (results.grad_z == qske_pkg::GRAD_POS_MAX) || (results.grad_z == qske_pkg::GRAD_NEG_MAX),
    "saturated flag set with no component at a limit")

endmodule

// ===== tb/quintic_spline_kernel_eval_tb.sv =====
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator testbench
// Drives neighbor pairs through the kernel under several register settings
// and compares each result item against a bit-exact fixed-point predictor.
// Both channels idle and stall at random to exercise backpressure.
// ----------------------------------------------------------------------------
module quintic_spline_kernel_eval_tb;
  import qske_pkg::*;

  localparam int PIPE_LATENCY = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int NUM_DIRECTED = 12;

  // Request selector values and the register index that maps to nothing.
  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_GRAD   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [63:0]  ONE_Q32    = 64'h1_0000_0000;
  localparam logic [63:0]  ONE_Q24    = 64'h0_0100_0000;
  localparam logic [127:0] POS_LIMIT  = (128'd1 << 47) - 128'd1;
  localparam logic [127:0] NEG_LIMIT  = 128'd1 << 47;

  typedef enum logic [1:0] {SEG_NONE, SEG_INNER, SEG_MID, SEG_OUTER} segment_t;

  typedef struct packed {
    logic                    func;
    logic [DIST_W-1:0]       distance;
    logic signed [SEP_W-1:0] sep_x;
    logic signed [SEP_W-1:0] sep_y;
    logic signed [SEP_W-1:0] sep_z;
  } pair_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]      weight;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     saturated;
  } kernel_out_t;

  // Holds the register copy, predicts each pair's kernel value and checks
  // the results in arrival order.
  class kernel_scoreboard;
    logic [CFG_W-1:0] inv_h;
    logic [CFG_W-1:0] weight_f;
    logic [CFG_W-1:0] grad_f;
    kernel_out_t      expected_q[$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      weight_pairs;
    int unsigned      grad_pairs;
    int unsigned      clipped;

    function new();
      inv_h    = INV_H_RESET;
      weight_f = WEIGHT_F_RESET;
      grad_f   = GRAD_F_RESET;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_INV_H:    inv_h = val;
        REG_WEIGHT_F: weight_f = val;
        REG_GRAD_F:   grad_f = val;
        default: ;
      endcase
    endfunction

    // Fourth and fifth powers of a Q.24 term, truncating at each product.
    function logic [63:0] quad_q24(logic [63:0] t);
      logic [63:0] sq;
      sq = (t * t) >> 24;
      return (sq * sq) >> 24;
    endfunction

    function logic [63:0] quint_q24(logic [63:0] t);
      return (quad_q24(t) * t) >> 24;
    endfunction

    // Scales the gradient magnitude by one separation component, with the
    // sign applied afterwards and clipping to the Q24.24 range.
    function logic signed [GRAD_W-1:0] scale_sep(logic [63:0] smag, logic grad_neg,
                                                 logic signed [SEP_W-1:0] sep,
                                                 output logic clip);
      logic [32:0]  vmag;
      logic [127:0] m;
      logic         neg;
      clip = 1'b0;
      vmag = sep[SEP_W-1] ? (33'h1_0000_0000 - {1'b0, sep}) : {1'b0, sep};
      m = (128'(vmag) * 128'(smag)) >> 16;
      neg = (grad_neg != sep[SEP_W-1]) && (m != 0);
      if (neg) begin
        if (m > NEG_LIMIT) begin
          m = NEG_LIMIT;
          clip = 1'b1;
        end
        m = 128'd0 - m;
      end else if (m > POS_LIMIT) begin
        m = POS_LIMIT;
        clip = 1'b1;
      end
      return m[GRAD_W-1:0];
    endfunction

    function kernel_out_t eval_kernel(pair_t p);
      logic [63:0]        q32, q, t3, t2, t1, smag;
      logic signed [63:0] br;
      logic [127:0]       wide;
      logic               grad_neg, clip_x, clip_y, clip_z;
      segment_t           seg;
      kernel_out_t        r;
      r = '0;
      q32 = 64'(p.distance) * 64'(inv_h);
      if (q32 < ONE_Q32) seg = SEG_INNER;
      else if (q32 < 2 * ONE_Q32) seg = SEG_MID;
      else if (q32 < 3 * ONE_Q32) seg = SEG_OUTER;
      else seg = SEG_NONE;
      if (seg == SEG_NONE) return r;

      q  = q32 >> 8;
      t3 = 3 * ONE_Q24 - q;
      t2 = 2 * ONE_Q24 - q;
      t1 = ONE_Q24 - q;

      if (p.func == FUNC_WEIGHT) begin
        // Weight bracket; rounding can push it below zero, which is clamped.
        br = $signed(quint_q24(t3));
        if (seg != SEG_OUTER) br = br - 6 * $signed(quint_q24(t2));
        if (seg == SEG_INNER) br = br + 15 * $signed(quint_q24(t1));
        if (br < 0) br = 0;
        wide = (128'(weight_f) * 128'(br)) >> 24;
        if (wide > POS_LIMIT) begin
          wide = POS_LIMIT;
          r.saturated = 1'b1;
        end
        r.weight = wide[WEIGHT_W-1:0];
      end else if (q32 != 0) begin
        // Derivative bracket; the gradient stays zero at zero distance.
        br = -5 * $signed(quad_q24(t3));
        if (seg != SEG_OUTER) br = br + 30 * $signed(quad_q24(t2));
        if (seg == SEG_INNER) br = br - 75 * $signed(quad_q24(t1));
        grad_neg = br < 0;
        smag = grad_neg ? -br : br;
        wide = (128'(grad_f) * 128'(smag)) >> 24;
        smag = wide[63:0];
        r.grad_x = scale_sep(smag, grad_neg, p.sep_x, clip_x);
        r.grad_y = scale_sep(smag, grad_neg, p.sep_y, clip_y);
        r.grad_z = scale_sep(smag, grad_neg, p.sep_z, clip_z);
        r.saturated = clip_x | clip_y | clip_z;
      end
      return r;
    endfunction

    function void note_pair(pair_t p);
      kernel_out_t e;
      e = eval_kernel(p);
      expected_q.push_back(e);
      if (p.func == FUNC_GRAD) grad_pairs++;
      else weight_pairs++;
      if (e.saturated) clipped++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] kernel check failed: %s", $time, msg);
    endtask

    task check_result(kernel_out_t got);
      kernel_out_t want;
      if (expected_q.size() == 0) begin
        report("result item arrived with no pair outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.weight !== want.weight)
        report($sformatf("item %0d weight %0h, predicted %0h", checked, got.weight,
                         want.weight));
      if (got.grad_x !== want.grad_x)
        report($sformatf("item %0d grad_x %0h, predicted %0h", checked, got.grad_x,
                         want.grad_x));
      if (got.grad_y !== want.grad_y)
        report($sformatf("item %0d grad_y %0h, predicted %0h", checked, got.grad_y,
                         want.grad_y));
      if (got.grad_z !== want.grad_z)
        report($sformatf("item %0d grad_z %0h, predicted %0h", checked, got.grad_z,
                         want.grad_z));
      if (got.saturated !== want.saturated)
        report($sformatf("item %0d saturated %0b, predicted %0b", checked, got.saturated,
                         want.saturated));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  qske_in_if  pairs_ch();
  qske_out_if kernel_ch();

  quintic_spline_kernel_eval dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (pairs_ch),
    .results   (kernel_ch)
  );

  kernel_scoreboard sb;
  bit pairs_calm;
  bit results_calm;
  int unsigned settings_seen;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Fixed pairs for unit smoothing length: zero distance, the segment knots, the points
  // just inside the first and third knots, beyond support and extreme separations.
  function automatic pair_t directed_pair(int i);
    pair_t p;
    p = '0;
    case (i)
      0: p.func = FUNC_WEIGHT;
      1: begin
        p.func = FUNC_GRAD;
        p.sep_x = 32'sh0001_0000;
        p.sep_y = -32'sh0001_0000;
      end
      2: p.distance = 32'd1;
      3: begin
        p = '{FUNC_GRAD, 32'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1};
      end
      4: p = '{FUNC_GRAD, 32'h0000_8000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000};
      5: p.distance = 32'h0000_FFFF;
      6: p.distance = 32'h0001_0000;
      7: p = '{FUNC_GRAD, 32'h0001_0000, 32'sd1, -32'sd1, 32'sh7FFF_FFFF};
      8: p = '{FUNC_GRAD, 32'h0002_0000, 32'sh8000_0000, 32'sh0001_0000, 32'sd0};
      9: p.distance = 32'h0002_FFFF;
      10: p = '{FUNC_GRAD, 32'h0003_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
      default: p.distance = 32'hFFFF_FFFF;
    endcase
    return p;
  endfunction

  function automatic logic signed [SEP_W-1:0] pick_sep();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // Most distances land inside the kernel support for the current length.
  function automatic pair_t random_pair();
    pair_t p;
    logic [63:0] reach;
    p.func = $urandom_range(0, 1);
    if (sb.inv_h == 0 || $urandom_range(0, 4) == 0) begin
      p.distance = $urandom;
    end else begin
      reach = (3 * ONE_Q32) / sb.inv_h + 1;
      if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
      p.distance = $urandom_range(0, reach[31:0]);
    end
    p.sep_x = pick_sep();
    p.sep_y = pick_sep();
    p.sep_z = pick_sep();
    return p;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] inv, logic [CFG_W-1:0] wf,
                                logic [CFG_W-1:0] gf);
    write_register(REG_INV_H, inv);
    write_register(REG_WEIGHT_F, wf);
    write_register(REG_GRAD_F, gf);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one pair after a random gap and waits for it to be taken.
  task automatic send_pair(pair_t p);
    int gap;
    if ($urandom_range(0, 19) == 0) pairs_calm = !pairs_calm;
    gap = pairs_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      pairs_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pairs_ch.valid    <= 1'b1;
    pairs_ch.func     <= p.func;
    pairs_ch.distance <= p.distance;
    pairs_ch.sep_x    <= p.sep_x;
    pairs_ch.sep_y    <= p.sep_y;
    pairs_ch.sep_z    <= p.sep_z;
    do @(posedge clk); while (pairs_ch.ready !== 1'b1);
    sb.note_pair(p);
  endtask

  // Takes result items with random stalls, for the whole run.
  task automatic drain_results();
    int gap;
    kernel_out_t got;
    forever begin
      if ($urandom_range(0, 19) == 0) results_calm = !results_calm;
      gap = results_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        kernel_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      kernel_ch.ready <= 1'b1;
      do @(posedge clk); while (kernel_ch.valid !== 1'b1);
      got.weight    = kernel_ch.weight;
      got.grad_x    = kernel_ch.grad_x;
      got.grad_y    = kernel_ch.grad_y;
      got.grad_z    = kernel_ch.grad_z;
      got.saturated = kernel_ch.saturated;
      sb.check_result(got);
    end
  endtask

  // One setting: optional fixed pairs, random pairs, then wait for results.
  task automatic run_phase(int n_random, bit with_directed);
    if (with_directed) begin
      for (int i = 0; i < NUM_DIRECTED; i++) send_pair(directed_pair(i));
    end
    for (int i = 0; i < n_random; i++) send_pair(random_pair());
    pairs_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    settings_seen++;
  endtask

  initial begin
    sb = new();
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= REG_INV_H;
    cfg_data          <= '0;
    pairs_ch.valid    <= 1'b0;
    pairs_ch.func     <= FUNC_WEIGHT;
    pairs_ch.distance <= '0;
    pairs_ch.sep_x    <= '0;
    pairs_ch.sep_y    <= '0;
    pairs_ch.sep_z    <= '0;
    kernel_ch.ready   <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    // Reset settings, then the same fixed pairs with full-scale factors.
    run_phase(40, 1'b1);
    apply_settings(32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(60, 1'b1);

    // Zero inverse smoothing length puts every pair at the origin.
    apply_settings(32'h0000_0000, 32'h0100_0000, 32'h0100_0000);
    run_phase(30, 1'b0);

    // Maximum inverse length: only the smallest distances stay in support.
    apply_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    run_phase(30, 1'b0);

    apply_settings($urandom_range(32'h0000_1000, 32'h0010_0000), $urandom, $urandom);
    run_phase(150, 1'b0);

    // A write to the unmapped index must leave the registers alone.
    write_register(REG_SPARE, $urandom);
    apply_settings(32'h0000_8000, 32'h0000_ADCE, 32'h0080_0000);
    run_phase(90, 1'b0);

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("Ran %0d weight and %0d gradient pairs over %0d register settings.",
             sb.weight_pairs, sb.grad_pairs, settings_seen);
    $display("Checked %0d results, %0d of them clipped; %0d field errors.",
             sb.checked, sb.clipped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/qske_pkg.sv
src/qske_if.sv
src/qske_pow_lane.sv
src/qske_grad_lane.sv
src/quintic_spline_kernel_eval.sv
tb/quintic_spline_kernel_eval_tb.sv
